>>> hdl/tdcepm_pkg.sv
`timescale 1ns / 1ps
package tdcepm_pkg;

  localparam int MAX_MULT = 8;
  localparam int IDX_W    = (MAX_MULT > 1) ? $clog2(MAX_MULT) : 1;

  localparam int CH_W   = 16;
  localparam int T_W    = 32;
  localparam int PAIR_W = 15;
  localparam int CNT_W  = 5;
  localparam int MC_W   = 15;

  localparam logic [CNT_W-1:0] CNT_MAX   = 5'd31;
  localparam logic [MC_W-1:0]  MULTI_MAX = 15'd32767;

  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_HIGH   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_ENABLE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SKIP_MULTI    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MIN_TOT       = 3'd4;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

  typedef struct packed {
    logic signed [T_W-1:0] window_low;
    logic signed [T_W-1:0] window_high;
    logic                  window_enable;
    logic                  skip_multi;
    logic signed [T_W-1:0] min_tot;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]       channel;
    logic signed [T_W-1:0] hit_time;
    logic signed [T_W-1:0] ref_time;
    logic                  event_end;
  } hit_t;

  typedef struct packed {
    logic                  kind;
    logic [CH_W-1:0]       lead_channel;
    logic signed [T_W-1:0] sync_time;
    logic [MC_W-1:0]       multi_count;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

>>> hdl/tdcepm_ifs.sv
`timescale 1ns / 1ps
interface tdcepm_hit_if import tdcepm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CH_W-1:0]       channel;
  logic signed [T_W-1:0] hit_time;
  logic signed [T_W-1:0] ref_time;
  logic                  event_end;

  modport source (output valid, channel, hit_time, ref_time, event_end, input ready);
  modport sink (input valid, channel, hit_time, ref_time, event_end, output ready);
endinterface

interface tdcepm_res_if import tdcepm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [CH_W-1:0]       lead_channel;
  logic signed [T_W-1:0] sync_time;
  logic [MC_W-1:0]       multi_count;
  logic                  last;

  modport source (output valid, kind, lead_channel, sync_time, multi_count, last,
                  input ready);
  modport sink (input valid, kind, lead_channel, sync_time, multi_count, last,
                output ready);
endinterface

>>> hdl/tdc_edge_pair_matcher_core.sv
`timescale 1ns / 1ps
// TDC leading/trailing edge pair matcher. Hits enter on the hit channel sorted by channel
// number; even channels are leading edges, the next odd channel the trailing edges of the
// same pair. Each hit is taken into an input register and processed, once the output
// queue has room, by one pass of compare and subtract logic against the open group,
// whose leading times sit in an 8-entry register buffer; the results it causes (a
// matched leading time when a group closes, a summary with the multi-hit count at the
// end of an event, at most two per hit) go into a 4-deep output queue. A hit can be
// accepted every cycle while the output queue has room. The output queue drains one
// result per cycle while the sink is ready, so a sustained rate of one hit per cycle
// holds as long as the results leave as fast as they are produced. Configuration goes
// through an APB port, one register per word.
module tdc_edge_pair_matcher_core import tdcepm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  tdcepm_hit_if.sink        hit,
  tdcepm_res_if.source      res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  hit_t  in_hit;
  push_t push;
  logic  room;
  res_t  out_res;

  assign in_hit.channel   = hit.channel;
  assign in_hit.hit_time  = hit.hit_time;
  assign in_hit.ref_time  = hit.ref_time;
  assign in_hit.event_end = hit.event_end;

  tdcepm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tdcepm_match u_match (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (hit.valid),
    .in_hit   (in_hit),
    .in_ready (hit.ready),
    .room     (room),
    .push     (push)
  );

  tdcepm_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_res   (out_res)
  );

  assign res.kind         = out_res.kind;
  assign res.lead_channel = out_res.lead_channel;
  assign res.sync_time    = out_res.sync_time;
  assign res.multi_count  = out_res.multi_count;
  assign res.last         = out_res.last;

endmodule

>>> hdl/tdcepm_regs.sv
`timescale 1ns / 1ps
module tdcepm_regs import tdcepm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_low    <= '0;
      cfg.window_high   <= '0;
      cfg.window_enable <= 1'b0;
      cfg.skip_multi    <= 1'b1;
      cfg.min_tot       <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_WINDOW_LOW:    cfg.window_low    <= pwdata[T_W-1:0];
        REG_WINDOW_HIGH:   cfg.window_high   <= pwdata[T_W-1:0];
        REG_WINDOW_ENABLE: cfg.window_enable <= pwdata[0];
        REG_SKIP_MULTI:    cfg.skip_multi    <= pwdata[0];
        REG_MIN_TOT:       cfg.min_tot       <= pwdata[T_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WINDOW_LOW:    prdata = cfg.window_low;
      REG_WINDOW_HIGH:   prdata = cfg.window_high;
      REG_WINDOW_ENABLE: prdata = {{(DATA_W-1){1'b0}}, cfg.window_enable};
      REG_SKIP_MULTI:    prdata = {{(DATA_W-1){1'b0}}, cfg.skip_multi};
      REG_MIN_TOT:       prdata = cfg.min_tot;
      default:           prdata = '0;
    endcase
  end

endmodule

>>> hdl/tdcepm_match.sv
`timescale 1ns / 1ps
module tdcepm_match import tdcepm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  input  hit_t  in_hit,
  output logic  in_ready,
  input  logic  room,
  output push_t push
);

  // input register
  hit_t hit_q;
  logic hit_valid;
  logic go;

  // group state
  logic [PAIR_W-1:0]     group_pair;
  logic                  group_open;
  logic [CNT_W-1:0]      lead_count;
  logic [CNT_W-1:0]      trail_count;
  logic                  first_accept_valid;
  logic signed [T_W-1:0] first_accept_time;
  logic [MC_W-1:0]       multi_total;
  logic signed [T_W-1:0] lead_store [MAX_MULT];
  logic signed [T_W-1:0] sync_store [MAX_MULT];

  logic [PAIR_W-1:0]     group_pair_next;
  logic                  group_open_next;
  logic [CNT_W-1:0]      lead_count_next;
  logic [CNT_W-1:0]      trail_count_next;
  logic                  first_accept_valid_next;
  logic signed [T_W-1:0] first_accept_time_next;
  logic [MC_W-1:0]       multi_total_next;

  logic [PAIR_W-1:0]     pair;
  logic                  close1;
  logic                  emit1;
  logic                  emit2;
  logic [CNT_W-1:0]      lc0;
  logic [CNT_W-1:0]      tc0;
  logic                  fav0;
  logic signed [T_W-1:0] fat0;
  logic [MC_W-1:0]       mt_a;
  logic [MC_W-1:0]       mt_b;
  logic                  lead_wr;
  logic [IDX_W-1:0]      lead_idx;
  logic [IDX_W-1:0]      trail_idx;
  logic [T_W:0]          sync_diff;
  logic signed [T_W-1:0] sync_sat;
  logic signed [T_W:0]   tot;
  logic signed [T_W-1:0] s_rd;
  logic                  inwin;
  logic                  ok;
  res_t                  rc1;
  res_t                  rc2;
  res_t                  rsum;
  res_t                  r0;
  res_t                  r1;
  logic [1:0]            cnt;

  function automatic logic group_emits(input logic [CNT_W-1:0] lc,
                                       input logic [CNT_W-1:0] tc,
                                       input logic fav, input cfg_t c);
    logic multi_ok;
    multi_ok = (lc <= CNT_W'(MAX_MULT)) && !c.skip_multi && c.window_enable;
    return (lc == tc) && (lc != '0) && fav && ((lc == CNT_W'(1)) || multi_ok);
  endfunction

  function automatic logic [MC_W-1:0] multi_inc(input logic [MC_W-1:0] mt,
                                                input logic [CNT_W-1:0] lc,
                                                input logic [CNT_W-1:0] tc);
    logic hit_multi;
    hit_multi = (lc == tc) && (lc > CNT_W'(1));
    return (hit_multi && mt != MULTI_MAX) ? mt + MC_W'(1) : mt;
  endfunction

  assign go       = hit_valid && room;
  assign in_ready = !hit_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (in_ready) begin
      hit_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hit_q <= in_hit;
    end
  end

  always_comb begin
    pair   = hit_q.channel[CH_W-1:1];
    close1 = group_open && (pair != group_pair);
    emit1  = close1 && group_emits(lead_count, trail_count, first_accept_valid, cfg);
    mt_a   = close1 ? multi_inc(multi_total, lead_count, trail_count) : multi_total;

    rc1.kind         = KIND_MATCH;
    rc1.lead_channel = {group_pair, 1'b0};
    rc1.sync_time    = first_accept_time;
    rc1.multi_count  = '0;
    rc1.last         = 1'b0;

    if (!group_open || close1) begin
      group_pair_next = pair;
      lc0  = '0;
      tc0  = '0;
      fav0 = 1'b0;
      fat0 = '0;
    end else begin
      group_pair_next = group_pair;
      lc0  = lead_count;
      tc0  = trail_count;
      fav0 = first_accept_valid;
      fat0 = first_accept_time;
    end

    // sync-relative time of a leading edge, saturated
    sync_diff = {hit_q.hit_time[T_W-1], hit_q.hit_time}
              - {hit_q.ref_time[T_W-1], hit_q.ref_time};
    if (sync_diff[T_W] != sync_diff[T_W-1]) begin
      sync_sat = sync_diff[T_W] ? {1'b1, {(T_W-1){1'b0}}} : {1'b0, {(T_W-1){1'b1}}};
    end else begin
      sync_sat = sync_diff[T_W-1:0];
    end

    lead_idx  = lc0[IDX_W-1:0];
    trail_idx = tc0[IDX_W-1:0];
    lead_wr   = !hit_q.channel[0] && (lc0 < CNT_W'(MAX_MULT));

    // trailing edge pairs with the stored leading edge of the same index
    tot   = {hit_q.hit_time[T_W-1], hit_q.hit_time}
          - {lead_store[trail_idx][T_W-1], lead_store[trail_idx]};
    s_rd  = sync_store[trail_idx];
    inwin = (s_rd > cfg.window_low) && (s_rd < cfg.window_high);
    if (lc0 == CNT_W'(1)) begin
      ok = (tot >= $signed({cfg.min_tot[T_W-1], cfg.min_tot}))
        && (!cfg.window_enable || inwin);
    end else begin
      ok = (tot > $signed({cfg.min_tot[T_W-1], cfg.min_tot})) && inwin;
    end

    lead_count_next         = lc0;
    trail_count_next        = tc0;
    first_accept_valid_next = fav0;
    first_accept_time_next  = fat0;
    if (!hit_q.channel[0]) begin
      if (lc0 != CNT_MAX) lead_count_next = lc0 + CNT_W'(1);
    end else begin
      if ((tc0 < lc0) && (tc0 < CNT_W'(MAX_MULT)) && !fav0 && ok) begin
        first_accept_valid_next = 1'b1;
        first_accept_time_next  = s_rd;
      end
      if (tc0 != CNT_MAX) trail_count_next = tc0 + CNT_W'(1);
    end

    // end of event closes the group and adds the summary
    emit2 = hit_q.event_end &&
            group_emits(lead_count_next, trail_count_next, first_accept_valid_next, cfg);
    mt_b  = hit_q.event_end ? multi_inc(mt_a, lead_count_next, trail_count_next) : mt_a;

    rc2.kind         = KIND_MATCH;
    rc2.lead_channel = {group_pair_next, 1'b0};
    rc2.sync_time    = first_accept_time_next;
    rc2.multi_count  = '0;
    rc2.last         = 1'b0;

    rsum.kind         = KIND_SUMMARY;
    rsum.lead_channel = '0;
    rsum.sync_time    = '0;
    rsum.multi_count  = mt_b;
    rsum.last         = 1'b0;

    group_open_next  = !hit_q.event_end;
    multi_total_next = hit_q.event_end ? '0 : mt_a;

    r0  = rc1;
    r1  = rc2;
    cnt = 2'd0;
    if (emit1) begin
      cnt = 2'd1;
    end
    if (emit2) begin
      if (cnt == 2'd0) r0 = rc2;
      else r1 = rc2;
      cnt = cnt + 2'd1;
    end
    if (hit_q.event_end) begin
      if (cnt == 2'd0) r0 = rsum;
      else r1 = rsum;
      cnt = cnt + 2'd1;
    end
    case (cnt)
      2'd1:    r0.last = 1'b1;
      2'd2:    r1.last = 1'b1;
      default: ;
    endcase

    push.n  = go ? cnt : 2'd0;
    push.r0 = r0;
    push.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_pair         <= '0;
      group_open         <= 1'b0;
      lead_count         <= '0;
      trail_count        <= '0;
      first_accept_valid <= 1'b0;
      first_accept_time  <= '0;
      multi_total        <= '0;
    end else if (go) begin
      group_pair         <= group_pair_next;
      group_open         <= group_open_next;
      lead_count         <= lead_count_next;
      trail_count        <= trail_count_next;
      first_accept_valid <= first_accept_valid_next;
      first_accept_time  <= first_accept_time_next;
      multi_total        <= multi_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && lead_wr) begin
      lead_store[lead_idx] <= hit_q.hit_time;
      sync_store[lead_idx] <= sync_sat;
    end
  end

endmodule

>>> hdl/tdcepm_outq.sv
`timescale 1ns / 1ps
module tdcepm_outq import tdcepm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  res_t                mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wptr;
  logic [OQ_PTR_W-1:0] rptr;
  logic [OQ_PTR_W:0]   count;
  logic [OQ_PTR_W:0]   count_next;
  logic                pop;

  assign out_valid  = (count != '0);
  assign out_res    = mem[rptr];
  assign pop        = out_valid && out_ready;
  assign room       = (count <= (OQ_PTR_W+1)'(OQ_DEPTH - 2));
  assign count_next = count + {{(OQ_PTR_W-1){1'b0}}, push.n} - {{OQ_PTR_W{1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + OQ_PTR_W'(push.n);
      if (pop) rptr <= rptr + OQ_PTR_W'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wptr] <= push.r0;
    if (push.n == 2'd2) mem[wptr + OQ_PTR_W'(1)] <= push.r1;
  end

endmodule

>>> hdl/tdcepm_checker.sv
`timescale 1ns / 1ps
module tdcepm_checker import tdcepm_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic              res_kind,
  input logic [CH_W-1:0]   res_lead_channel,
  input logic [T_W-1:0]    res_sync_time,
  input logic [MC_W-1:0]   res_multi_count,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_kind) &&
      $stable(res_lead_channel) && $stable(res_sync_time) && $stable(res_multi_count))
    else $error("stalled result changed");

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result present after reset");

  a_summary_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_SUMMARY |-> res_lead_channel == '0 && res_sync_time == '0)
    else $error("summary carries match fields");

  a_match_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_MATCH |-> res_multi_count == '0 && !res_lead_channel[0])
    else $error("matched result malformed");

  // window_low read back after a write
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_WINDOW_LOW
      |=> paddr[ADDR_W-1:2] != REG_WINDOW_LOW || prdata == $past(pwdata))
    else $error("register readback mismatch");

endmodule

bind tdc_edge_pair_matcher_core tdcepm_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_kind         (res.kind),
  .res_lead_channel (res.lead_channel),
  .res_sync_time    (res.sync_time),
  .res_multi_count  (res.multi_count),
  .psel             (psel),
  .penable          (penable),
  .pwrite           (pwrite),
  .paddr            (paddr),
  .pwdata           (pwdata),
  .prdata           (prdata)
);
